// ===== rtl/ndd_pkg.sv =====
// types and constants for the newton divided-difference interpolator
// no dependencies
package ndd_pkg;

  localparam int unsigned DW = 68;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_SET  = 3'd1,
    ST_DUP     = 3'd2,
    ST_OVERFLW = 3'd3,
    ST_SAT     = 3'd4
  } status_t;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic               last_node;
    logic signed [31:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic is_div;
    logic neg;
  } arith_cmd_t;

endpackage

// ===== rtl/newton_divided_difference_interp.sv =====
// Newton divided-difference interpolator, signed fixed point.
// Input channel (in_valid/in_stall/in_data): opcode 0 loads one node (x, y);
// a load with last_node set closes the set and computes the coefficients
// in place, then returns one transfer with value 0 and the set status.
// Opcode 1 evaluates the Newton polynomial at query_x and returns one
// transfer with the value and status. Plain loads return nothing.
// All products and quotients run through one bit-serial unit, one
// operation at a time.
// A plain load only stores the node; an item answered at once (no set,
// duplicate set, single node) goes straight to the output state.
// Closing an n-node set runs n(n-1)/2 divisions, each an operand read,
// a start and a write-back of the coefficient (DRD, DRUN, DWR).
// An evaluation runs n-1 steps (operand read and two multiplications),
// each adding its product to the running sum with saturation.
// One item is worked on at a time. The output register holds a result
// while out_stall is high; the next input is still taken and worked on,
// and its result waits until the register is free.
// Reset clears the node count, set flags and all handshake state; the
// node and coefficient stores are not cleared and need no clearing pass.
// Depends on ndd_pkg and ndd_serial_unit.
module newton_divided_difference_interp #(
  parameter int MAX_NODES = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ndd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ndd_pkg::out_item_t out_data
);
  import ndd_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NW = $clog2(MAX_NODES + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DRD   = 8'b0000_0010,
    S_DRUN  = 8'b0000_0100,
    S_DWR   = 8'b0000_1000,
    S_ERD   = 8'b0001_0000,
    S_MP    = 8'b0010_0000,
    S_MC    = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;
  logic signed [31:0] xmem [MAX_NODES];
  logic signed [31:0] cmem [MAX_NODES];
  logic [NW-1:0] node_count;
  logic          set_ready;
  logic [2:0]    set_error;
  logic [AW-1:0] ii, jj;
  logic signed [31:0] xa, xb, ca, cb, qx, res_acc, prod;
  logic          sat_acc;
  out_item_t     out_r, out_q;
  logic          out_load;
  arith_cmd_t    cmd;
  logic [DW-1:0] op_a, op_b;
  logic          u_done, u_sat;
  logic signed [31:0] u_res;
  logic signed [DW-1:0] den, num, dq, sum;

  ndd_serial_unit #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk, .rst, .cmd, .op_a, .op_b,
    .done(u_done), .res(u_res), .sat(u_sat)
  );

  assign in_stall  = (state != S_IDLE);
  assign out_data  = out_q;
  assign out_load  = (state == S_OUT) && (!out_valid || !out_stall);

  function automatic logic [DW-1:0] mag_f(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  assign den = DW'(xa) - DW'(xb);
  assign num = DW'(ca) - DW'(cb);
  assign dq  = DW'(qx) - DW'(xb);
  assign sum = DW'(res_acc) + DW'(u_res);

  always_comb begin
    cmd  = '0;
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_DRUN: begin
        cmd.start  = (den != '0);
        cmd.is_div = 1'b1;
        cmd.neg    = num[DW-1] ^ den[DW-1];
        op_a       = mag_f(num);
        op_b       = mag_f(den);
      end
      S_ERD: begin
        cmd.start = 1'b1;
        cmd.neg   = dq[DW-1] ^ prod[31];
        op_a      = mag_f(dq);
        op_b      = mag_f(DW'(prod));
      end
      S_MP: begin
        cmd.start = u_done;
        cmd.neg   = ca[31] ^ u_res[31];
        op_a      = mag_f(DW'(ca));
        op_b      = mag_f(DW'(u_res));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= '0;
      set_ready  <= 1'b0;
      set_error  <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          if (in_data.opcode == OP_LOAD) begin
            logic [NW-1:0] cnt;
            logic [2:0]    err;
            cnt = set_ready ? '0 : node_count;
            err = set_ready ? 3'(ST_OK) : set_error;
            if (cnt < NW'(MAX_NODES)) begin
              xmem[cnt[AW-1:0]] <= in_data.node_x;
              cmem[cnt[AW-1:0]] <= in_data.node_y;
              cnt = cnt + 1'b1;
            end else if (err != 3'(ST_DUP)) begin
              err = 3'(ST_OVERFLW);
            end
            node_count <= cnt;
            set_error  <= err;
            set_ready  <= in_data.last_node;
            sat_acc    <= 1'b0;
            if (in_data.last_node) begin
              if (cnt > NW'(1)) begin
                jj    <= AW'(1);
                ii    <= AW'(cnt - 1'b1);
                state <= S_DRD;
              end else begin
                out_r <= '{value: '0, status: err};
                state <= S_OUT;
              end
            end
          end else begin
            qx      <= in_data.query_x;
            sat_acc <= 1'b0;
            if (!set_ready || node_count == '0) begin
              out_r <= '{value: '0, status: 3'(ST_NO_SET)};
              state <= S_OUT;
            end else if (set_error == 3'(ST_DUP)) begin
              out_r <= '{value: '0, status: 3'(ST_DUP)};
              state <= S_OUT;
            end else if (node_count == NW'(1)) begin
              out_r <= '{value: cmem[0], status: set_error};
              state <= S_OUT;
            end else begin
              res_acc <= cmem[0];
              prod    <= 32'sd1 <<< FRAC_BITS;
              ii      <= AW'(1);
              state   <= S_ERD;
              xb      <= xmem[0];
            end
          end
        end
        S_DRD: begin
          // read operands for coeff[ii] update
          xa    <= xmem[ii];
          xb    <= xmem[ii - jj];
          ca    <= cmem[ii];
          cb    <= cmem[ii - AW'(1)];
          state <= S_DRUN;
        end
        S_DRUN: begin
          if (den == '0) begin
            set_error <= 3'(ST_DUP);
            out_r     <= '{value: '0, status: 3'(ST_DUP)};
            state     <= S_OUT;
          end else begin
            state <= S_DWR;
          end
        end
        S_DWR: if (u_done) begin
          cmem[ii] <= u_res;
          sat_acc  <= sat_acc | u_sat;
          if (ii != jj) begin
            ii    <= ii - AW'(1);
            state <= S_DRD;
          end else if (NW'(jj) != (node_count - NW'(1))) begin
            jj    <= jj + AW'(1);
            ii    <= AW'(node_count - 1'b1);
            state <= S_DRD;
          end else begin
            logic [2:0] e;
            e = (set_error == 3'(ST_OK) && (sat_acc || u_sat)) ? 3'(ST_SAT) : set_error;
            set_error <= e;
            out_r     <= '{value: '0, status: e};
            state     <= S_OUT;
          end
        end
        S_ERD: begin
          ca    <= cmem[ii];
          state <= S_MP;
        end
        S_MP: if (u_done) begin
          prod    <= u_res;
          sat_acc <= sat_acc | u_sat;
          state   <= S_MC;
        end
        S_MC: if (u_done) begin
          logic signed [31:0] r;
          logic s;
          s = sat_acc | u_sat;
          if (sum > DW'(64'sh7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF; s = 1'b1;
          end else if (sum < -DW'(64'sh8000_0000)) begin
            r = 32'sh8000_0000; s = 1'b1;
          end else begin
            r = sum[31:0];
          end
          res_acc <= r;
          sat_acc <= s;
          if (NW'(ii) == (node_count - NW'(1))) begin
            out_r <= '{value: r,
                       status: (set_error != 3'(ST_OK)) ? set_error
                               : (s ? 3'(ST_SAT) : 3'(ST_OK))};
            state <= S_OUT;
          end else begin
            xb    <= xmem[ii];
            ii    <= ii + AW'(1);
            state <= S_ERD;
          end
        end
        S_OUT: if (out_load) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register, refilled as soon as the held transfer goes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_q <= out_r;
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_out_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT) else $error("stray result");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    node_count <= NW'(MAX_NODES)) else $error("node count overflow");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("accept while busy");

endmodule

// ===== rtl/ndd_serial_unit.sv =====
// bit-serial magnitude multiplier and divider with signed saturation
// depends on ndd_pkg
module ndd_serial_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ndd_pkg::arith_cmd_t      cmd,
  input  logic [ndd_pkg::DW-1:0]   op_a,
  input  logic [ndd_pkg::DW-1:0]   op_b,
  output logic                     done,
  output logic signed [31:0]       res,
  output logic                     sat
);
  import ndd_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] acc, sa, sb, rem;
  logic [CW-1:0] cnt;
  logic          busy, div_mode, neg_r;
  logic [DW-1:0] mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy     <= 1'b1;
        div_mode <= cmd.is_div;
        neg_r    <= cmd.neg;
        acc      <= '0;
        rem      <= '0;
        cnt      <= CW'(DW);
        sa       <= cmd.is_div ? (op_a << FRAC_BITS) : op_a;
        sb       <= op_b;
      end else if (busy) begin
        if (div_mode) begin
          // restoring division, one quotient bit a cycle
          if ({rem[DW-2:0], sa[DW-1]} >= sb) begin
            rem <= {rem[DW-2:0], sa[DW-1]} - sb;
            acc <= {acc[DW-2:0], 1'b1};
          end else begin
            rem <= {rem[DW-2:0], sa[DW-1]};
            acc <= {acc[DW-2:0], 1'b0};
          end
          sa <= {sa[DW-2:0], 1'b0};
        end else begin
          // shift-add multiply, one multiplier bit a cycle
          if (sb[0]) acc <= acc + sa;
          sa <= {sa[DW-2:0], 1'b0};
          sb <= {1'b0, sb[DW-1:1]};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    mag = div_mode ? acc : (acc >> FRAC_BITS);
    sat = 1'b0;
    if (neg_r) begin
      if (mag > DW'(64'h8000_0000)) begin
        sat = 1'b1;
        res = 32'sh8000_0000;
      end else begin
        res = 32'(-mag);
      end
    end else if (mag > DW'(64'h7FFF_FFFF)) begin
      sat = 1'b1;
      res = 32'sh7FFF_FFFF;
    end else begin
      res = mag[31:0];
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy && !done |-> !cmd.start) else $error("start while busy");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0) else $error("count ran out");

endmodule
